FILE: sv/mdp_pkg.sv
package mdp_pkg;

    // padding marker byte placed right after the message
    localparam logic [7:0] PAD_MARKER = 8'h80;
    // word slot inside a 64-byte block that precedes the length word
    localparam logic [2:0] LAST_PAD_SLOT = 3'd6;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PAD  = 3'b010,
        ST_LEN  = 3'b100
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic pad_emit;
        logic len_emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_pad_slot;
    } status_t;

    // swap byte order of a 64-bit word
    function automatic logic [63:0] byte_reverse(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*(7-i) +: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

endpackage

FILE: sv/mdp_ctrl.sv
module mdp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  mdp_pkg::status_t status,
    output mdp_pkg::cmd_t    cmd
);

    mdp_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // input ready only while taking message bytes and output slot frees up
    assign s_tready = (state_reg == mdp_pkg::ST_IDLE) && status.out_free;

    // command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            mdp_pkg::ST_IDLE: begin
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept && s_tlast) begin
                    state_next = mdp_pkg::ST_PAD;
                end
            end
            mdp_pkg::ST_PAD: begin
                cmd.pad_emit = status.out_free;
                if (status.out_free && status.last_pad_slot) begin
                    state_next = mdp_pkg::ST_LEN;
                end
            end
            mdp_pkg::ST_LEN: begin
                cmd.len_emit = status.out_free;
                if (status.out_free) begin
                    state_next = mdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mdp_datapath.sv
module mdp_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  mdp_pkg::cmd_t    cmd,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,
    output logic             m_tlast,
    output mdp_pkg::status_t status
);

    logic [55:0] partial_reg,  partial_next;
    logic [2:0]  fill_reg,     fill_next;
    logic [60:0] count_reg,    count_next;
    logic [2:0]  slot_reg,     slot_next;
    logic        first_reg,    first_next;
    logic        big_end_reg;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_word_reg,  out_word_next;
    logic        out_last_reg,  out_last_next;

    logic [63:0] merged;
    logic [63:0] marked;
    logic [63:0] bit_len;

    // byte inserted at the current fill lane
    always_comb begin
        merged = {8'h00, partial_reg};
        merged[{fill_reg, 3'b000} +: 8] = s_tdata;
        marked = {8'h00, partial_reg};
        marked[{fill_reg, 3'b000} +: 8] = mdp_pkg::PAD_MARKER;
    end

    assign bit_len = {count_reg, 3'b000};

    assign status.out_free      = !out_valid_reg || m_tready;
    assign status.last_pad_slot = (slot_reg == mdp_pkg::LAST_PAD_SLOT);

    // next-state logic for packing, padding and length
    always_comb begin
        partial_next   = partial_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        if (cmd.accept) begin
            if (s_tuser) begin
                count_next = count_reg + 61'd1;
                if (fill_reg == 3'd7) begin
                    out_valid_next = 1'b1;
                    out_word_next  = merged;
                    out_last_next  = 1'b0;
                    partial_next   = '0;
                    fill_next      = '0;
                end else begin
                    partial_next = merged[55:0];
                    fill_next    = fill_reg + 3'd1;
                end
            end
            slot_next  = count_next[5:3];
            first_next = 1'b1;
        end
        if (cmd.pad_emit) begin
            out_valid_next = 1'b1;
            out_word_next  = first_reg ? marked : 64'd0;
            out_last_next  = 1'b0;
            first_next     = 1'b0;
            slot_next      = slot_reg + 3'd1;
        end
        if (cmd.len_emit) begin
            out_valid_next = 1'b1;
            out_word_next  = big_end_reg ? mdp_pkg::byte_reverse(bit_len) : bit_len;
            out_last_next  = 1'b1;
            partial_next   = '0;
            fill_next      = '0;
            count_next     = '0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg   <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            big_end_reg   <= 1'b0;
        end else begin
            partial_reg   <= partial_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                big_end_reg <= cfg_wdata;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/md_message_padder.sv
// Message padder for MD5 / SHA-1 style hashing.
// Slave channel: one message byte per word, tdata = data byte, tuser = byte
// present flag, tlast = end of message (may come with or without a byte).
// Master channel: 64-bit words of the padded stream, earliest byte in bits
// 7:0; tlast marks the final word, which carries the bit length.
// cfg_we / cfg_wdata set the length byte order: 0 little-endian (MD5),
// 1 big-endian (SHA). Write only while the block is idle.
// Throughput: one byte per cycle while the message streams in and the
// output register is free; a completed word is loaded at the edge that
// accepts its eighth byte and shows on m_tvalid / m_tdata the following
// cycle. After the word carrying tlast, input is held off while the
// controller emits one padding word per cycle while the output is free
// (1 to 8 words, up to the block's seventh slot) and then the length word.
// A single output register sits between the channels; when m_tready is low
// it holds its word, and input or padding stalls until it drains.
// Reset (aresetn low, synchronous) clears the packed word, byte count,
// output valid and the byte-order setting (little-endian).
module md_message_padder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] out_word
    output logic        m_tlast,   // out_last
    input  logic        cfg_we,
    input  logic        cfg_wdata  // [0] length_big_endian
);

    mdp_pkg::cmd_t    cmd;
    mdp_pkg::status_t status;

    // controller
    mdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    mdp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .status    (status)
    );

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.pad_emit, cmd.len_emit}))
        else $error("more than one datapath command at once");

    a_len_word_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.len_emit |=> m_tvalid && m_tlast)
        else $error("length word not presented as last");

    a_pad_word_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pad_emit |=> m_tvalid && !m_tlast)
        else $error("padding word flagged as last");

    a_no_input_while_padding: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pad_emit || cmd.len_emit) |-> !s_tready)
        else $error("input ready during padding");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

    // one byte-channel word as the sender sees it
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } byte_item_t;

    // one padded-stream word as the receiver should see it
    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } padded_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;

    md_message_padder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // bytes waiting to be offered, and padded words still owed by the block
    byte_item_t   byte_q[$];
    padded_word_t padded_words_q[$];

    // padder state as predicted
    logic        len_be   = 1'b0;
    logic [63:0] acc_word = '0;
    int          acc_fill = 0;
    logic [60:0] msg_len  = '0;

    int fail_count    = 0;
    int words_checked = 0;
    int msgs_padded   = 0;
    int items_taken   = 0;
    int hold_asked    = 0;
    int hold_served   = 0;

    logic         in_taken = 1'b0;
    byte_item_t   tx_item;
    padded_word_t head_word;
    int           tx_burst_left = 0;
    int           tx_gap_left   = 0;
    int           rx_hold_left  = 0;
    int           rx_mode       = 0;
    logic [31:0]  rx_cycle      = '0;

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #1600000;
        $display("md_message_padder regression: fail");
        $finish;
    end

    // drop one byte into the word being packed, emit it once full
    task automatic pack_byte(input logic [7:0] b, input logic tag_last);
        padded_word_t w;
        acc_word[8*acc_fill +: 8] = b;
        acc_fill++;
        if (acc_fill == 8) begin
            w.word = acc_word;
            w.last = tag_last;
            padded_words_q.push_back(w);
            acc_word = '0;
            acc_fill = 0;
        end
    endtask

    // predict the words caused by one accepted byte-channel word
    task automatic pad_message_byte(input logic [7:0] b, input logic has, input logic fin);
        logic [63:0] length_field;
        logic [63:0] len_swapped;
        int          pos;
        int          zeros;
        if (has) begin
            pack_byte(b, 1'b0);
            msg_len = msg_len + 61'd1;
        end
        if (fin) begin
            length_field = {msg_len, 3'b000};
            pos          = int'((msg_len + 61'd1) & 61'd63);
            zeros        = (56 - pos) & 63;
            pack_byte(mdp_pkg::PAD_MARKER, 1'b0);
            for (int k = 0; k < zeros; k++) begin
                pack_byte(8'h00, 1'b0);
            end
            // sha order: most significant length byte goes first
            if (len_be) begin
                for (int i = 0; i < 8; i++) begin
                    len_swapped[8*i +: 8] = length_field[8*(7-i) +: 8];
                end
                length_field = len_swapped;
            end
            for (int i = 0; i < 8; i++) begin
                pack_byte(length_field[8*i +: 8], i == 7);
            end
            acc_word = '0;
            acc_fill = 0;
            msg_len  = '0;
            msgs_padded++;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (tx_gap_left != 0 || byte_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap_left != 0) begin
                    tx_gap_left <= tx_gap_left - 1;
                end
            end else begin
                tx_item = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tx_item.data;
                s_tuser  <= tx_item.has;
                s_tlast  <= tx_item.fin;
                if (tx_burst_left <= 1) begin
                    tx_burst_left <= $urandom_range(1, 48);
                    tx_gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    tx_burst_left <= tx_burst_left - 1;
                end
            end
        end
    end

    // receiver: switches between random stall patterns, long holds on request
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (rx_hold_left != 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_asked != hold_served) begin
            m_tready     <= 1'b0;
            rx_hold_left <= 300;
            hold_served  <= hold_served + 1;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // predict on accepted bytes, check accepted words
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pad_message_byte(s_tdata, s_tuser, s_tlast);
                items_taken++;
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
            if (m_tvalid && m_tready) begin
                if (padded_words_q.size() == 0) begin
                    $error("unexpected word: out_word %h out_last %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    head_word = padded_words_q.pop_front();
                    words_checked++;
                    if (m_tdata !== head_word.word) begin
                        $error("out_word: expected %h, got %h", head_word.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head_word.last) begin
                        $error("out_last: expected %b, got %b", head_word.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] data, input logic has, input logic fin);
        byte_item_t it;
        it.data = data;
        it.has  = has;
        it.fin  = fin;
        byte_q.push_back(it);
    endtask

    // one message of random content; lengths lean on block boundaries
    task automatic queue_random_message(output int n_items);
        int   pick;
        int   len;
        logic ends_on_byte;
        n_items = 0;
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            len = $urandom_range(0, 9);
        end else if (pick < 10) begin
            len = $urandom_range(10, 50);
        end else if (pick < 15) begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(54, 58) : $urandom_range(62, 66);
        end else if (pick < 18) begin
            len = ($urandom_range(0, 1) == 0) ? 56 : 120;
        end else begin
            len = $urandom_range(96, 130);
        end
        ends_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++) begin
            // occasional idle word in the middle of a message
            if ($urandom_range(0, 11) == 0) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                n_items++;
            end
            queue_byte(8'($urandom_range(0, 255)), 1'b1, ends_on_byte && (k == len - 1));
            n_items++;
        end
        if (!ends_on_byte) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            n_items++;
        end
    endtask

    task automatic queue_random_messages(input int target);
        int got;
        int n;
        got = 0;
        @(posedge aclk);
        while (got < target) begin
            queue_random_message(n);
            got += n;
        end
    endtask

    // wait until every byte is taken and every word has come back
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || padded_words_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_byte_order(input logic be);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = be;
        @(negedge aclk);
        cfg_we = 1'b0;
        len_be = be;
    endtask

    // test sequence
    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: little-endian length
        write_byte_order(1'b0);
        @(posedge aclk);
        // empty message
        queue_byte(8'hA5, 1'b0, 1'b1);
        // single byte carried on the end word
        queue_byte(8'hFF, 1'b1, 1'b1);
        // idle words around extreme bytes, then an empty end word
        queue_byte(8'h5A, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        // seven bytes, last one on the end word
        for (int i = 0; i < 7; i++) begin
            queue_byte(8'h01 << i, 1'b1, i == 6);
        end
        // one full word, then an empty end word
        for (int i = 0; i < 8; i++) begin
            queue_byte(8'hFE >> i, 1'b1, 1'b0);
        end
        queue_byte(8'h00, 1'b0, 1'b1);
        wait_drained();

        // big-endian length, with a long receiver hold while bytes keep coming
        write_byte_order(1'b1);
        queue_random_messages(120);
        hold_asked++;
        wait_drained();

        // back to little-endian, sender pauses halfway until all words are in
        write_byte_order(1'b0);
        queue_random_messages(60);
        wait_drained();
        queue_random_messages(60);
        wait_drained();

        write_byte_order(1'b1);
        queue_random_messages(120);
        wait_drained();

        if (padded_words_q.size() != 0) begin
            $error("%0d padded words never arrived", padded_words_q.size());
            fail_count++;
        end
        $display("covered %0d byte-channel words and %0d padded messages, both length orders",
                 items_taken, msgs_padded);
        $display("checked %0d output words, including a 300-cycle output stall", words_checked);
        if (fail_count == 0) begin
            $display("md_message_padder regression: pass");
        end else begin
            $display("md_message_padder regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/mdp_pkg.sv
sv/mdp_ctrl.sv
sv/mdp_datapath.sv
sv/md_message_padder.sv
tb/sv/tb_top.sv
